### src/bbc_pkg.sv
// Package with the types and codes shared by the block buffer cache files.
package bbc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_MISS,
    ST_EVRD,
    ST_EVICT,
    ST_CHKID,
    ST_RESP
  } state_t;

  localparam logic [1:0] FUNC_GET     = 2'd0;
  localparam logic [1:0] FUNC_RELEASE = 2'd1;
  localparam logic [1:0] FUNC_FILL    = 2'd2;
  localparam logic [1:0] FUNC_UNUSED  = 2'd3;

  localparam logic [1:0] PLACE_FREE     = 2'd0;
  localparam logic [1:0] PLACE_HELD     = 2'd1;
  localparam logic [1:0] PLACE_RELEASED = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NO_BUFFER = 2'd1;
  localparam logic [1:0] STATUS_NOT_HELD  = 2'd2;
  localparam logic [1:0] STATUS_UNUSED    = 2'd3;

  typedef struct packed {
    logic [1:0] place;
    logic       data_valid;
  } info_t;

endpackage

### src/block_buffer_cache_lru_unit.sv
// Top level of the LRU block buffer cache: request sequencer over the tag and link memories.
// Each request word gives one response word. A get request walks the released list from
// its oldest buffer, one tag per cycle out of the tag memory, until a tag matches or the
// list ends. A miss takes the next free buffer, or else evicts the oldest released buffer.
// Buffers leave the free pool in index order and never return to it. A new request is
// taken only while no other is in progress, but a finished response may still wait in
// the output register.
module block_buffer_cache_lru_unit #(
  parameter int NUM_BUFFERS = 64,
  parameter int ADDR_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // block_addr[31:0], buffer_id[37:32], zero fill
  input  logic [1:0]  s_tuser,  // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // granted_buffer[5:0], hit[6], need_read[7], status[9:8]
);
  import bbc_pkg::*;

  localparam int IDX_W = $clog2(NUM_BUFFERS);
  localparam int CNT_W = $clog2(NUM_BUFFERS + 1);
  localparam int TAG_W = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam logic [CNT_W-1:0] N_CNT = CNT_W'(NUM_BUFFERS);

  state_t state, state_next;

  logic [1:0]       func_r;
  logic [TAG_W-1:0] addr_r;
  logic [5:0]       id_r;
  logic [IDX_W-1:0] cur, cur_next;
  logic [CNT_W-1:0] k, k_next;
  logic [IDX_W-1:0] lru_head, lru_head_next, lru_tail, lru_tail_next;
  logic [CNT_W-1:0] lru_count, lru_count_next, free_used, free_used_next;
  logic [IDX_W-1:0] res_granted, res_granted_next;
  logic             res_hit, res_hit_next, res_need, res_need_next;
  logic [1:0]       res_status, res_status_next;

  logic [TAG_W-1:0] tag_mem [NUM_BUFFERS];
  logic [IDX_W-1:0] next_mem [NUM_BUFFERS];
  logic [IDX_W-1:0] prev_mem [NUM_BUFFERS];
  info_t            info_mem [NUM_BUFFERS];

  logic [TAG_W-1:0] tag_q;
  logic [IDX_W-1:0] next_q, prev_q;
  info_t            info_q;
  logic [IDX_W-1:0] rd_addr;

  logic             tag_we, next_we, prev_we, info_we;
  logic [IDX_W-1:0] tag_wa, next_wa, next_wd, prev_wa, prev_wd, info_wa;
  info_t            info_wd;

  logic             accept, out_free, match, at_end, free_avail, held_ok;
  logic [IDX_W-1:0] in_idx, id_idx, ul_b;
  logic             ul;

  assign s_tready   = (state == ST_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign in_idx     = IDX_W'(s_tdata[37:32]);
  assign id_idx     = IDX_W'(id_r);
  assign match      = (tag_q == addr_r);
  assign at_end     = (CNT_W'(k + 1'b1) == lru_count);
  assign free_avail = (free_used != N_CNT);
  assign held_ok    = (id_r < NUM_BUFFERS) && (CNT_W'(id_idx) < free_used) &&
                      (info_q.place == PLACE_HELD);

  always_comb begin
    unique case (state)
      ST_SRCH: rd_addr = next_q;
      ST_EVRD: rd_addr = lru_head;
      default: rd_addr = (s_tuser == FUNC_GET) ? lru_head : in_idx;
    endcase
  end

  always_ff @(posedge clk) begin
    tag_q  <= tag_mem[rd_addr];
    next_q <= next_mem[rd_addr];
    prev_q <= prev_mem[rd_addr];
    info_q <= info_mem[rd_addr];
    if (tag_we) begin
      tag_mem[tag_wa] <= addr_r;
    end
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    if (info_we) begin
      info_mem[info_wa] <= info_wd;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (s_tuser == FUNC_GET) begin
            state_next = (lru_count != '0) ? ST_SRCH : ST_MISS;
          end else if (s_tuser == FUNC_RELEASE || s_tuser == FUNC_FILL) begin
            state_next = ST_CHKID;
          end else begin
            state_next = ST_RESP;
          end
        end
      end
      ST_SRCH: begin
        if (match) begin
          state_next = ST_RESP;
        end else if (at_end) begin
          state_next = ST_MISS;
        end
      end
      ST_MISS: begin
        if (!free_avail && lru_count != '0) begin
          state_next = ST_EVRD;
        end else begin
          state_next = ST_RESP;
        end
      end
      ST_EVRD:  state_next = ST_EVICT;
      ST_EVICT: state_next = ST_RESP;
      ST_CHKID: state_next = ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cur_next         = cur;
    k_next           = k;
    lru_head_next    = lru_head;
    lru_tail_next    = lru_tail;
    lru_count_next   = lru_count;
    free_used_next   = free_used;
    res_granted_next = res_granted;
    res_hit_next     = res_hit;
    res_need_next    = res_need;
    res_status_next  = res_status;
    tag_we  = 1'b0;
    tag_wa  = cur;
    next_we = 1'b0;
    next_wa = prev_q;
    next_wd = next_q;
    prev_we = 1'b0;
    prev_wa = next_q;
    prev_wd = prev_q;
    info_we = 1'b0;
    info_wa = cur;
    info_wd = '{place: PLACE_HELD, data_valid: 1'b0};
    ul      = 1'b0;
    ul_b    = cur;
    unique case (state)
      ST_IDLE: begin
        cur_next         = lru_head;
        k_next           = '0;
        res_granted_next = '0;
        res_hit_next     = 1'b0;
        res_need_next    = 1'b0;
        res_status_next  = STATUS_OK;
      end
      ST_SRCH: begin
        if (match) begin
          ul               = 1'b1;
          ul_b             = cur;
          info_we          = 1'b1;
          info_wa          = cur;
          info_wd          = '{place: PLACE_HELD, data_valid: info_q.data_valid};
          res_granted_next = cur;
          res_hit_next     = 1'b1;
          res_need_next    = !info_q.data_valid;
        end else begin
          cur_next = next_q;
          k_next   = CNT_W'(k + 1'b1);
        end
      end
      ST_MISS: begin
        if (free_avail) begin
          tag_we           = 1'b1;
          tag_wa           = IDX_W'(free_used);
          info_we          = 1'b1;
          info_wa          = IDX_W'(free_used);
          free_used_next   = CNT_W'(free_used + 1'b1);
          res_granted_next = IDX_W'(free_used);
          res_need_next    = 1'b1;
        end else if (lru_count == '0) begin
          res_status_next = STATUS_NO_BUFFER;
        end
      end
      ST_EVICT: begin
        ul               = 1'b1;
        ul_b             = lru_head;
        tag_we           = 1'b1;
        tag_wa           = lru_head;
        info_we          = 1'b1;
        info_wa          = lru_head;
        res_granted_next = lru_head;
        res_need_next    = 1'b1;
      end
      ST_CHKID: begin
        if (!held_ok) begin
          res_status_next = STATUS_NOT_HELD;
        end else if (func_r == FUNC_RELEASE) begin
          info_we = 1'b1;
          info_wa = id_idx;
          info_wd = '{place: PLACE_RELEASED, data_valid: info_q.data_valid};
          if (lru_count == '0) begin
            lru_head_next = id_idx;
          end else begin
            next_we = 1'b1;
            next_wa = lru_tail;
            next_wd = id_idx;
            prev_we = 1'b1;
            prev_wa = id_idx;
            prev_wd = lru_tail;
          end
          lru_tail_next  = id_idx;
          lru_count_next = CNT_W'(lru_count + 1'b1);
        end else begin
          info_we = 1'b1;
          info_wa = id_idx;
          info_wd = '{place: PLACE_HELD, data_valid: 1'b1};
        end
      end
      default: begin
      end
    endcase
    if (ul) begin
      if (lru_count <= CNT_W'(1)) begin
        lru_count_next = '0;
        lru_head_next  = '0;
        lru_tail_next  = '0;
      end else begin
        if (ul_b == lru_head) begin
          lru_head_next = next_q;
        end else begin
          next_we = 1'b1;
          next_wa = prev_q;
          next_wd = next_q;
        end
        if (ul_b == lru_tail) begin
          lru_tail_next = prev_q;
        end else begin
          prev_we = 1'b1;
          prev_wa = next_q;
          prev_wd = prev_q;
        end
        lru_count_next = CNT_W'(lru_count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      m_tvalid  <= 1'b0;
      lru_head  <= '0;
      lru_tail  <= '0;
      lru_count <= '0;
      free_used <= '0;
    end else begin
      state     <= state_next;
      lru_head  <= lru_head_next;
      lru_tail  <= lru_tail_next;
      lru_count <= lru_count_next;
      free_used <= free_used_next;
      if (state == ST_RESP && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur         <= cur_next;
    k           <= k_next;
    res_granted <= res_granted_next;
    res_hit     <= res_hit_next;
    res_need    <= res_need_next;
    res_status  <= res_status_next;
    if (accept) begin
      func_r <= s_tuser;
      addr_r <= s_tdata[TAG_W-1:0];
      id_r   <= s_tdata[37:32];
    end
    if (state == ST_RESP && out_free) begin
      m_tdata <= {6'b0, res_status, res_need, res_hit, 6'(res_granted)};
    end
  end

endmodule

### src/bbc_checker.sv
// Port checker for the block buffer cache and its bind to the top level.
module bbc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);
  import bbc_pkg::*;

  property p_status_code;
    @(posedge clk) disable iff (rst) m_tvalid |-> m_tdata[9:8] != STATUS_UNUSED;
  endproperty
  a_status_code: assert property (p_status_code) else $error("bad status code");

  property p_fail_zero;
    @(posedge clk) disable iff (rst)
      (m_tvalid && m_tdata[9:8] != STATUS_OK) |-> m_tdata[7:0] == 8'd0;
  endproperty
  a_fail_zero: assert property (p_fail_zero) else $error("failed request with fields set");

  property p_one_at_a_time;
    @(posedge clk) disable iff (rst) (s_tvalid && s_tready) |=> !s_tready;
  endproperty
  a_one_at_a_time: assert property (p_one_at_a_time) else $error("request taken while busy");

  property p_hold;
    @(posedge clk) disable iff (rst)
      (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata));
  endproperty
  a_hold: assert property (p_hold) else $error("stalled response word changed");

endmodule

bind block_buffer_cache_lru_unit bbc_checker u_bbc_checker (.*);

### bench/block_buffer_cache_lru_unit_tb.sv
// Self-checking testbench for the LRU block buffer cache with a scoreboard and random traffic.
module block_buffer_cache_lru_unit_tb;
  import bbc_pkg::*;

  localparam int NBUF = 64;

  class cache_scoreboard;
    logic [31:0] tags [NBUF];
    bit          valid_mark [NBUF];
    logic [1:0]  place [NBUF];
    int          nxt [NBUF];
    int          prv [NBUF];
    int          rel_head, rel_tail, rel_count;
    int          free_head, free_count;
    logic [15:0] pending [$];
    int          errors;
    int          hits, misses, exhausted, not_held;

    function new();
      for (int i = 0; i < NBUF; i++) begin
        tags[i] = '0; valid_mark[i] = 0; place[i] = PLACE_FREE; nxt[i] = 0; prv[i] = 0;
      end
      rel_head = 0; rel_tail = 0; rel_count = 0; free_head = 0; free_count = NBUF;
      errors = 0; hits = 0; misses = 0; exhausted = 0; not_held = 0;
    endfunction

    function void unlink(int b);
      int p, n;
      p = prv[b];
      n = nxt[b];
      if (rel_count <= 1) begin
        rel_count = 0; rel_head = 0; rel_tail = 0;
        return;
      end
      if (b == rel_head) rel_head = n;
      else nxt[p] = n;
      if (b == rel_tail) rel_tail = p;
      else prv[n] = p;
      rel_count--;
    endfunction

    function void note_request(logic [1:0] func, logic [31:0] addr, logic [5:0] id);
      logic [5:0] gb;
      logic       h, nr;
      logic [1:0] st;
      int cur, b;
      bit found;
      gb = '0; h = 0; nr = 0; st = STATUS_OK; found = 0; b = 0;
      if (func == FUNC_GET) begin
        cur = rel_head;
        for (int k = 0; k < rel_count; k++) begin
          if (tags[cur] == addr) begin
            found = 1; b = cur; break;
          end
          cur = nxt[cur];
        end
        if (found) begin
          unlink(b);
          place[b] = PLACE_HELD; gb = 6'(b); h = 1; nr = !valid_mark[b];
          hits++;
        end else if (free_count > 0 || rel_count > 0) begin
          if (free_count > 0) begin
            b = free_head; free_head = (free_head + 1) % NBUF; free_count--;
          end else begin
            b = rel_head; unlink(b);
          end
          tags[b] = addr; valid_mark[b] = 0; place[b] = PLACE_HELD; gb = 6'(b); nr = 1;
          misses++;
        end else begin
          st = STATUS_NO_BUFFER; exhausted++;
        end
      end else if (func == FUNC_RELEASE || func == FUNC_FILL) begin
        if (place[id] != PLACE_HELD) begin
          st = STATUS_NOT_HELD; not_held++;
        end else if (func == FUNC_RELEASE) begin
          place[id] = PLACE_RELEASED;
          if (rel_count == 0) rel_head = id;
          else begin
            nxt[rel_tail] = id; prv[id] = rel_tail;
          end
          rel_tail = id; rel_count++;
        end else begin
          valid_mark[id] = 1;
        end
      end
      pending.insert(pending.size(), {6'd0, st, nr, h, gb});
    endfunction

    task automatic report(string what, logic [15:0] got, logic [15:0] want);
      $display("MISMATCH %s: got %h expected %h", what, got, want);
      errors++;
    endtask

    task automatic check_response(logic [15:0] got);
      logic [15:0] want;
      if (pending.size() == 0) begin
        report("unexpected word", got, 16'h0);
        return;
      end
      want = pending[0];
      pending.delete(0);
      if (got[5:0] != want[5:0]) report("granted_buffer", got, want);
      if (got[6] != want[6]) report("hit", got, want);
      if (got[7] != want[7]) report("need_read", got, want);
      if (got[9:8] != want[9:8]) report("status", got, want);
    endtask
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [15:0] m_tdata;

  cache_scoreboard sb = new();
  bit stall_long = 0;
  logic [31:0] addr_pool [8];
  logic [5:0]  held [$];

  block_buffer_cache_lru_unit dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  task automatic send(logic [1:0] func, logic [31:0] addr, logic [5:0] id);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= func;
    s_tdata <= {2'b00, id, addr};
    do @(posedge clk); while (!s_tready);
    sb.note_request(func, addr, id);
  endtask

  task automatic pick_get();
    logic [31:0] a;
    a = ($urandom_range(0, 3) != 0) ? addr_pool[$urandom_range(0, 7)] : $urandom;
    send(FUNC_GET, a, 6'($urandom));
  endtask

  // Returns the id of a buffer to work on: mostly one the bench believes is held.
  function automatic logic [5:0] pick_id();
    if (held.size() > 0 && $urandom_range(0, 4) != 0) return held[$urandom_range(0, held.size() - 1)];
    return 6'($urandom);
  endfunction

  task automatic random_item();
    int r;
    logic [5:0] id;
    r = $urandom_range(0, 99);
    if (r < 45) pick_get();
    else if (r < 70) begin
      id = pick_id();
      send(FUNC_RELEASE, $urandom, id);
    end else if (r < 95) send(FUNC_FILL, $urandom, pick_id());
    else send(FUNC_UNUSED, $urandom, 6'($urandom));
  endtask

  // Keeps a rough list of held ids from the responses seen, to steer releases.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_response(m_tdata);
      if (m_tdata[9:8] == STATUS_OK && m_tdata[7:6] != 2'b00) held.insert(held.size(), m_tdata[5:0]);
      if (held.size() > 40) held.delete(0);
    end
  end

  initial begin
    int wait_n;
    forever begin
      @(posedge clk);
      if (stall_long) m_tready <= 0;
      else begin
        wait_n = $urandom_range(0, 3);
        if (wait_n == 0 || $urandom_range(0, 7) == 0) m_tready <= 1;
        else begin
          m_tready <= 0;
          repeat (wait_n) @(posedge clk);
          m_tready <= 1;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < 8; i++) addr_pool[i] = $urandom;
    addr_pool[0] = 32'h0;
    addr_pool[1] = 32'hFFFF_FFFF;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed part: address extremes, hit, fill, double release, bad ids, unused code.
    send(FUNC_GET, 32'h0, 6'h3F);
    send(FUNC_GET, 32'hFFFF_FFFF, 6'h00);
    send(FUNC_FILL, 32'h0, 6'd0);
    send(FUNC_RELEASE, 32'h0, 6'd0);
    send(FUNC_RELEASE, 32'h0, 6'd0);
    send(FUNC_FILL, 32'h0, 6'd0);
    send(FUNC_RELEASE, 32'h0, 6'd63);
    send(FUNC_GET, 32'h0, 6'd0);
    send(FUNC_RELEASE, 32'h0, 6'd1);
    send(FUNC_RELEASE, 32'h0, 6'd0);
    send(FUNC_GET, 32'hFFFF_FFFF, 6'd0);
    send(FUNC_UNUSED, 32'hFFFF_FFFF, 6'h3F);
    send(FUNC_RELEASE, 32'h0, 6'd1);
    // Repeat get of address 0: a hit on its released buffer, a release of a buffer not held, then a hit again.
    send(FUNC_GET, 32'h0, 6'd0);
    send(FUNC_RELEASE, 32'h0, 6'd2);
    send(FUNC_RELEASE, 32'h0, 6'd0);
    send(FUNC_GET, 32'h0, 6'd0);
    // Exhaust the pool: hold every buffer, then ask for one more.
    for (int i = 0; i < 64; i++) send(FUNC_GET, $urandom, 6'd0);
    send(FUNC_GET, 32'h1234_5678, 6'd0);
    for (int i = 0; i < 64; i++) send(FUNC_RELEASE, 32'h0, 6'(i));
    // Long receiver stall while requests keep coming.
    fork
      begin
        stall_long = 1;
        repeat (400) @(posedge clk);
        stall_long = 0;
      end
      for (int i = 0; i < 12; i++) random_item();
    join
    for (int i = 0; i < 1700; i++) random_item();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("Covered %0d hits, %0d misses, %0d empty-pool and %0d not-held responses.",
             sb.hits, sb.misses, sb.exhausted, sb.not_held);
    if (sb.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20000000;
    $display("Timeout waiting for responses");
    $display("Test completed with failures");
    $finish;
  end

endmodule

### sim.f
src/bbc_pkg.sv
src/block_buffer_cache_lru_unit.sv
src/bbc_checker.sv
bench/block_buffer_cache_lru_unit_tb.sv
